// File: hw/rtl/mrfc_pkg.sv
// Shared definitions for the Modbus RTU frame checker.
// Holds function codes, CRC constants, the controller/datapath interface types
// and the CRC byte step. No dependencies.
`default_nettype none

package mrfc_pkg;

  localparam logic [7:0] FC_READ_COILS      = 8'h01;
  localparam logic [7:0] FC_READ_INPUTS     = 8'h02;
  localparam logic [7:0] FC_READ_HOLDING    = 8'h03;
  localparam logic [7:0] FC_READ_INPUT_REGS = 8'h04;
  localparam logic [7:0] FC_WRITE_COIL      = 8'h05;
  localparam logic [7:0] FC_WRITE_REG       = 8'h06;
  localparam logic [7:0] FC_WRITE_COILS     = 8'h0F;
  localparam logic [7:0] FC_WRITE_REGS      = 8'h10;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [9:0] POS_MAX      = 10'd1023;
  localparam logic [9:0] MIN_FRAME    = 10'd4;
  localparam logic [9:0] SINGLE_LEN   = 10'd8;
  localparam logic [9:0] READ_EXTRA   = 10'd5;
  localparam logic [9:0] MULTI_EXTRA  = 10'd9;

  typedef struct packed {
    logic accept_byte;
    logic clear;
    logic start_words;
    logic read_en;
    logic read_second;
    logic capture_first;
    logic load_simple;
    logic load_words;
    logic advance_words;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_ok;
    logic is_regs;
    logic words_done;
    logic out_free;
  } ctrl_status_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/modbus_rtu_frame_checker.sv
// Top level of the Modbus RTU frame checker.
// Instantiates mrfc_ctrl and mrfc_datapath; uses mrfc_pkg.
// Bytes of a receive buffer are taken one per clock cycle while the controller is
// idle. The byte marked as last of its buffer is followed by frame evaluation;
// then a buffer that is invalid, or a valid frame of another function code,
// gives its single result as soon as the output register is free. Read holding
// or input register responses give their results one by one, each after the two
// reads of the word store and the load of that result, and the input stays
// closed until the last result is loaded, also while the output register is
// stalled. The final result may wait in the output register while bytes of the
// next buffer are taken.
`default_nettype none

module modbus_rtu_frame_checker
  import mrfc_pkg::*;
#(
  parameter int DATA_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_of_buffer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        frame_valid,
  output logic [7:0]  function_code,
  output logic [15:0] start_address,
  output logic [1:0]  value_count,
  output logic [15:0] first_value,
  output logic [15:0] second_value,
  output logic        last_result
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  mrfc_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .last_of_buffer (last_of_buffer),
    .in_ready       (in_ready),
    .status         (status),
    .cmd            (cmd)
  );

  mrfc_datapath #(
    .DATA_DEPTH (DATA_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_valid   (frame_valid),
    .function_code (function_code),
    .start_address (start_address),
    .value_count   (value_count),
    .first_value   (first_value),
    .second_value  (second_value),
    .last_result   (last_result)
  );

endmodule

`default_nettype wire

// File: hw/rtl/mrfc_ctrl.sv
// Controller state machine of the Modbus RTU frame checker.
// Sequences byte intake, frame evaluation and result emission; uses mrfc_pkg.
`default_nettype none

module mrfc_ctrl
  import mrfc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         last_of_buffer,
  output logic         in_ready,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_RD1  = 3'd2;
  localparam logic [2:0] S_RD2  = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept_byte = 1'b1;
          if (last_of_buffer) begin
            state_next = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (status.frame_ok && status.is_regs) begin
          cmd.start_words = 1'b1;
          state_next = S_RD1;
        end else if (status.out_free) begin
          cmd.load_simple = 1'b1;
          cmd.clear = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RD1: begin
        cmd.read_en = 1'b1;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.read_en = 1'b1;
        cmd.read_second = 1'b1;
        cmd.capture_first = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (status.out_free) begin
          cmd.load_words = 1'b1;
          if (status.words_done) begin
            cmd.clear = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.advance_words = 1'b1;
            state_next = S_RD1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/mrfc_datapath.sv
// Datapath of the Modbus RTU frame checker: frame fields, CRC, byte store,
// word counter and the output register. Driven by mrfc_ctrl; uses mrfc_pkg.
`default_nettype none

module mrfc_datapath
  import mrfc_pkg::*;
#(
  parameter int DATA_DEPTH = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  ctrl_cmd_t    cmd,
  output ctrl_status_t status,
  input  logic [7:0]   data_byte,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         frame_valid,
  output logic [7:0]   function_code,
  output logic [15:0]  start_address,
  output logic [1:0]   value_count,
  output logic [15:0]  first_value,
  output logic [15:0]  second_value,
  output logic         last_result
);

  localparam int ROWS  = DATA_DEPTH / 2;
  localparam int ROW_W = $clog2(ROWS);

  logic [9:0]  byte_position;
  logic [15:0] running_crc;
  logic [15:0] computed_crc;
  logic [15:0] received_crc;
  logic [7:0]  code_seen;
  logic [7:0]  count_byte;
  logic [9:0]  expected_length;
  logic [15:0] address_word;
  logic [15:0] value_word;
  logic [7:0]  word_index;
  logic [15:0] read_word;
  logic [15:0] first_word;

  logic [7:0] bank_hi [ROWS];
  logic [7:0] bank_lo [ROWS];

  logic [10:0]      pos_plus1;
  logic [10:0]      pos_plus2;
  logic [9:0]       store_index;
  logic             store_en;
  logic [ROW_W-1:0] store_row;
  logic [ROW_W-1:0] read_row;
  logic [7:0]       read_index;
  logic [6:0]       word_total;
  logic             is_single;
  logic [1:0]       word_cnt;

  assign pos_plus1   = {1'b0, byte_position} + 11'd1;
  assign pos_plus2   = {1'b0, byte_position} + 11'd2;
  assign store_index = byte_position - 10'd3;
  assign store_en    = (byte_position >= 10'd3) && ({1'b0, store_index} < 11'(DATA_DEPTH));
  assign store_row   = store_index[ROW_W:1];
  assign read_index  = cmd.read_second ? word_index + 8'd1 : word_index;
  assign read_row    = read_index[ROW_W-1:0];
  assign word_total  = count_byte[7:1];
  assign is_single   = (code_seen == FC_WRITE_COIL) || (code_seen == FC_WRITE_REG);

  always_comb begin
    word_cnt = 2'd0;
    if ({1'b0, word_index} + 9'd1 < {2'b00, word_total}) begin
      word_cnt = 2'd2;
    end else if (word_index < {1'b0, word_total}) begin
      word_cnt = 2'd1;
    end
  end

  assign status.frame_ok = (byte_position >= MIN_FRAME) && (expected_length != 10'd0)
                           && (byte_position >= expected_length)
                           && (computed_crc == received_crc);
  assign status.is_regs = (code_seen == FC_READ_HOLDING) || (code_seen == FC_READ_INPUT_REGS);
  assign status.words_done = ({1'b0, word_index} + 9'd2) >= {2'b00, word_total};
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      byte_position   <= '0;
      running_crc     <= CRC_INIT;
      computed_crc    <= '0;
      received_crc    <= '0;
      code_seen       <= '0;
      count_byte      <= '0;
      expected_length <= '0;
      address_word    <= '0;
      value_word      <= '0;
    end else if (cmd.accept_byte) begin
      case (byte_position)
        10'd1: begin
          code_seen <= data_byte;
          if (data_byte == FC_WRITE_COIL || data_byte == FC_WRITE_REG) begin
            expected_length <= SINGLE_LEN;
          end
        end
        10'd2: begin
          count_byte <= data_byte;
          address_word[15:8] <= data_byte;
          if (code_seen inside {[FC_READ_COILS:FC_READ_INPUT_REGS]}) begin
            expected_length <= {2'b00, data_byte} + READ_EXTRA;
          end
        end
        10'd3: address_word[7:0] <= data_byte;
        10'd4: value_word[15:8] <= data_byte;
        10'd5: value_word[7:0] <= data_byte;
        10'd6: begin
          if (code_seen == FC_WRITE_COILS || code_seen == FC_WRITE_REGS) begin
            expected_length <= {2'b00, data_byte} + MULTI_EXTRA;
          end
        end
        default: begin
        end
      endcase
      if (expected_length == 10'd0 || pos_plus2 < {1'b0, expected_length}) begin
        running_crc <= crc_step(running_crc, data_byte);
      end else if (pos_plus2 == {1'b0, expected_length}) begin
        computed_crc <= running_crc;
        received_crc <= {8'h00, data_byte};
      end else if (pos_plus1 == {1'b0, expected_length}) begin
        received_crc[15:8] <= data_byte;
      end
      if (byte_position != POS_MAX) begin
        byte_position <= pos_plus1[9:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_byte && store_en) begin
      if (store_index[0]) begin
        bank_lo[store_row] <= data_byte;
      end else begin
        bank_hi[store_row] <= data_byte;
      end
    end
    if (cmd.read_en) begin
      read_word <= {bank_hi[read_row], bank_lo[read_row]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_words) begin
      word_index <= '0;
    end else if (cmd.advance_words) begin
      word_index <= word_index + 8'd2;
    end
    if (cmd.capture_first) begin
      first_word <= read_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_simple || cmd.load_words) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_simple) begin
      frame_valid   <= status.frame_ok;
      function_code <= status.frame_ok ? code_seen : 8'h00;
      start_address <= (status.frame_ok && is_single) ? address_word : 16'h0000;
      value_count   <= (status.frame_ok && is_single) ? 2'd1 : 2'd0;
      first_value   <= (status.frame_ok && is_single) ? value_word : 16'h0000;
      second_value  <= 16'h0000;
      last_result   <= 1'b1;
    end else if (cmd.load_words) begin
      frame_valid   <= 1'b1;
      function_code <= code_seen;
      start_address <= 16'h0000;
      value_count   <= word_cnt;
      first_value   <= (word_cnt != 2'd0) ? first_word : 16'h0000;
      second_value  <= (word_cnt == 2'd2) ? read_word : 16'h0000;
      last_result   <= status.words_done;
    end
  end

endmodule

`default_nettype wire

// File: tb/tb_modbus_rtu_frame_checker.sv
// Self-checking testbench for modbus_rtu_frame_checker.
// Builds Modbus RTU buffers (good frames, corrupted ones, noise), predicts each result with
// its own frame decoder, and checks results in order. Depends on mrfc_pkg and the block.
`default_nettype none

module tb_modbus_rtu_frame_checker;
  import mrfc_pkg::*;

  localparam int STALL_PCT = 9;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_BUFFERS = 6;
  localparam logic [7:0] FC_NONE = 8'h00;
  localparam logic [7:0] FC_UNUSED = 8'h07;
  localparam logic [7:0] FC_TOP = 8'hFF;

  typedef logic [7:0] byte_q_t [$];

  typedef struct packed {
    logic        frame_valid;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [1:0]  value_count;
    logic [15:0] first_value;
    logic [15:0] second_value;
    logic        last_result;
  } frame_result_t;

  class frame_result_tracker;
    frame_result_t pending_results[$];
    int unsigned mismatches;
    logic [9:0]  position;
    logic [15:0] crc_run;
    logic [15:0] crc_frame;
    logic [15:0] crc_trailer;
    logic [7:0]  code;
    logic [7:0]  count;
    logic [9:0]  frame_len;
    logic [15:0] addr_word;
    logic [15:0] val_word;
    logic [7:0]  payload [256];

    function new();
      mismatches = 0;
      clear_frame();
    endfunction

    static function logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
    endfunction

    function void clear_frame();
      position = '0;
      crc_run = CRC_INIT;
      crc_frame = '0;
      crc_trailer = '0;
      code = '0;
      count = '0;
      frame_len = '0;
      addr_word = '0;
      val_word = '0;
    endfunction

    function logic [15:0] payload_word(int idx);
      return {payload[idx % 256], payload[(idx + 1) % 256]};
    endfunction

    function void add_result(logic ok, logic [7:0] fc, logic [15:0] addr, logic [1:0] cnt,
                             logic [15:0] v1, logic [15:0] v2, logic last);
      pending_results.push_back({ok, fc, addr, cnt, v1, v2, last});
    endfunction

    // Advances the decoder by one accepted byte and queues the results it causes.
    function void take_byte(logic [7:0] b, logic last);
      int p;
      int n;
      int words;
      int results;
      logic [1:0]  cnt;
      logic [15:0] v1;
      logic [15:0] v2;
      logic ok;
      p = position;
      case (p)
        1: begin
          code = b;
          if (code == FC_WRITE_COIL || code == FC_WRITE_REG) frame_len = SINGLE_LEN;
        end
        2: begin
          count = b;
          addr_word[15:8] = b;
          if (code >= FC_READ_COILS && code <= FC_READ_INPUT_REGS) begin
            frame_len = {2'b00, b} + READ_EXTRA;
          end
        end
        3: addr_word[7:0] = b;
        4: val_word[15:8] = b;
        5: val_word[7:0] = b;
        6: begin
          if (code == FC_WRITE_COILS || code == FC_WRITE_REGS) frame_len = {2'b00, b} + MULTI_EXTRA;
        end
        default: ;
      endcase
      if (p >= 3 && p < 259) payload[p - 3] = b;
      if (frame_len == 0 || p + 2 < frame_len) begin
        crc_run = crc_byte(crc_run, b);
      end else if (p + 2 == frame_len) begin
        crc_frame = crc_run;
        crc_trailer = {8'h00, b};
      end else if (p + 1 == frame_len) begin
        crc_trailer[15:8] = b;
      end
      if (position != POS_MAX) position = position + 10'd1;
      if (!last) return;
      n = position;
      ok = n >= MIN_FRAME && frame_len != 0 && n >= frame_len && crc_frame == crc_trailer;
      if (!ok) begin
        add_result(1'b0, 8'h00, 16'h0000, 2'd0, 16'h0000, 16'h0000, 1'b1);
      end else if (code == FC_READ_HOLDING || code == FC_READ_INPUT_REGS) begin
        words = count / 2;
        results = (words == 0) ? 1 : (words + 1) / 2;
        for (int r = 0; r < results; r++) begin
          cnt = 2'd0;
          v1 = '0;
          v2 = '0;
          if (2 * r < words) begin
            v1 = payload_word(4 * r);
            cnt = 2'd1;
          end
          if (2 * r + 1 < words) begin
            v2 = payload_word(4 * r + 2);
            cnt = 2'd2;
          end
          add_result(1'b1, code, 16'h0000, cnt, v1, v2, r + 1 == results);
        end
      end else if (code == FC_WRITE_COIL || code == FC_WRITE_REG) begin
        add_result(1'b1, code, addr_word, 2'd1, val_word, 16'h0000, 1'b1);
      end else begin
        add_result(1'b1, code, 16'h0000, 2'd0, 16'h0000, 16'h0000, 1'b1);
      end
      clear_frame();
    endfunction

    task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch in %s: got %h, expected %h", what, got, want);
      mismatches++;
    endtask

    task check_result(frame_result_t got);
      frame_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", got.first_value, 16'h0000);
        return;
      end
      want = pending_results.pop_front();
      if (got.frame_valid !== want.frame_valid) begin
        report_mismatch("frame_valid", 16'(got.frame_valid), 16'(want.frame_valid));
      end
      if (got.function_code !== want.function_code) begin
        report_mismatch("function_code", 16'(got.function_code), 16'(want.function_code));
      end
      if (got.start_address !== want.start_address) begin
        report_mismatch("start_address", got.start_address, want.start_address);
      end
      if (got.value_count !== want.value_count) begin
        report_mismatch("value_count", 16'(got.value_count), 16'(want.value_count));
      end
      if (got.first_value !== want.first_value) begin
        report_mismatch("first_value", got.first_value, want.first_value);
      end
      if (got.second_value !== want.second_value) begin
        report_mismatch("second_value", got.second_value, want.second_value);
      end
      if (got.last_result !== want.last_result) begin
        report_mismatch("last_result", 16'(got.last_result), 16'(want.last_result));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        last_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        frame_valid;
  logic [7:0]  function_code;
  logic [15:0] start_address;
  logic [1:0]  value_count;
  logic [15:0] first_value;
  logic [15:0] second_value;
  logic        last_result;
  logic        steady = 1'b0;
  int unsigned quiet_cycles = 0;
  frame_result_tracker tracker;

  logic [7:0] known_codes [8] = '{FC_READ_COILS, FC_READ_INPUTS, FC_READ_HOLDING,
                                  FC_READ_INPUT_REGS, FC_WRITE_COIL, FC_WRITE_REG,
                                  FC_WRITE_COILS, FC_WRITE_REGS};

  modbus_rtu_frame_checker u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .last_of_buffer (last_of_buffer),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_valid    (frame_valid),
    .function_code  (function_code),
    .start_address  (start_address),
    .value_count    (value_count),
    .first_value    (first_value),
    .second_value   (second_value),
    .last_result    (last_result)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        tracker.check_result({frame_valid, function_code, start_address, value_count,
                              first_value, second_value, last_result});
      end
      out_ready <= steady || ($urandom_range(99) >= STALL_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("modbus_rtu_frame_checker regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] fill_byte(int fill);
    return (fill < 0) ? 8'($urandom_range(255)) : fill[7:0];
  endfunction

  // A frame with a correct trailer; fill < 0 gives random content.
  function automatic byte_q_t build_frame(logic [7:0] fc, int count, int fill);
    byte_q_t f;
    logic [15:0] crc;
    f.push_back(fill_byte(fill));
    f.push_back(fc);
    if (fc == FC_WRITE_COIL || fc == FC_WRITE_REG) begin
      repeat (4) f.push_back(fill_byte(fill));
    end else begin
      if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS) repeat (4) f.push_back(fill_byte(fill));
      f.push_back(count[7:0]);
      repeat (count) f.push_back(fill_byte(fill));
    end
    crc = CRC_INIT;
    foreach (f[i]) crc = frame_result_tracker::crc_byte(crc, f[i]);
    f.push_back(crc[7:0]);
    f.push_back(crc[15:8]);
    return f;
  endfunction

  function automatic byte_q_t random_buffer();
    byte_q_t f;
    int kind;
    int count;
    kind = $urandom_range(99);
    count = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(12);
    f = build_frame(known_codes[$urandom_range(7)], count, -1);
    if (kind < 70) begin
    end else if (kind < 78) begin
      f[$urandom_range(f.size() - 1)] ^= 8'h01 << $urandom_range(7);
    end else if (kind < 84) begin
      repeat ($urandom_range(f.size() - 1, 1)) void'(f.pop_back());
    end else if (kind < 90) begin
      repeat ($urandom_range(6, 1)) f.push_back(fill_byte(-1));
    end else if (kind < 95) begin
      f[1] = fill_byte(-1);
    end else begin
      f.delete();
      repeat ($urandom_range(10, 1)) f.push_back(fill_byte(-1));
    end
    return f;
  endfunction

  task automatic send_buffer(byte_q_t bytes);
    for (int i = 0; i < bytes.size(); i++) begin
      while (!steady && $urandom_range(99) < STALL_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      data_byte <= bytes[i];
      last_of_buffer <= (i == bytes.size() - 1);
      do @(posedge clk); while (!in_ready);
      tracker.take_byte(bytes[i], i == bytes.size() - 1);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_results.size() != 0);
  endtask

  initial begin
    byte_q_t frame;
    tracker = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_buffer(build_frame(FC_READ_COILS, 0, 0));
    send_buffer(build_frame(FC_READ_INPUTS, 3, -1));
    send_buffer(build_frame(FC_READ_HOLDING, 0, -1));
    send_buffer(build_frame(FC_READ_INPUT_REGS, 1, -1));
    send_buffer(build_frame(FC_READ_HOLDING, 6, -1));
    send_buffer(build_frame(FC_READ_INPUT_REGS, 7, 255));
    send_buffer(build_frame(FC_READ_HOLDING, 8, 0));
    send_buffer(build_frame(FC_WRITE_COIL, 0, 255));
    send_buffer(build_frame(FC_WRITE_REG, 0, 0));
    send_buffer(build_frame(FC_WRITE_COILS, 0, -1));
    send_buffer(build_frame(FC_WRITE_REGS, 4, -1));
    frame = build_frame(FC_WRITE_REG, 0, -1);
    frame[4] ^= 8'h10;
    send_buffer(frame);
    send_buffer('{8'h11});
    send_buffer('{8'h11, FC_WRITE_REG, 8'h00});
    send_buffer(build_frame(FC_NONE, 2, -1));
    send_buffer(build_frame(FC_UNUSED, 2, -1));
    send_buffer(build_frame(FC_TOP, 2, -1));
    frame = build_frame(FC_WRITE_REGS, 2, -1);
    while (frame.size() > 6) void'(frame.pop_back());
    send_buffer(frame);
    frame = build_frame(FC_READ_HOLDING, 8, -1);
    void'(frame.pop_back());
    send_buffer(frame);
    frame = build_frame(FC_WRITE_REG, 0, -1);
    repeat (3) frame.push_back(fill_byte(-1));
    send_buffer(frame);
    wait_for_results();

    for (int k = 0; k < RANDOM_BUFFERS; k++) begin
      if (k == 1) wait_for_results();
      steady = (k >= 2 && k < 5);
      send_buffer(random_buffer());
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("modbus_rtu_frame_checker regression: pass");
    end else begin
      $display("modbus_rtu_frame_checker regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
